// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define SPK_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define SPK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg
// Types and constants shared by the spectral peak picker.
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int MAX_BINS    = 4096;
    localparam int TOP_COUNT   = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam int SMP_W  = 16;
    localparam int MAG_W  = SMP_W + 1;
    localparam int SQ_W   = 31;
    localparam int PWR_W  = 32;
    localparam int BIN_W  = 12;
    localparam int CNT_W  = $clog2(MAX_BINS);
    localparam int IDX_W  = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int Q_AW   = $clog2(QUEUE_DEPTH);
    localparam int Q_CW   = Q_AW + 1;

    localparam logic KIND_POWER = 1'b0;
    localparam logic KIND_PEAK  = 1'b1;

    typedef struct packed {
        logic signed [SMP_W-1:0] real_part;
        logic signed [SMP_W-1:0] imag_part;
        logic                    frame_end;
    } t_in;

    typedef struct packed {
        logic             item_kind;
        logic [PWR_W-1:0] power_value;
        logic [BIN_W-1:0] bin_index;
        logic             run_last;
    } t_out;

    typedef struct packed {
        logic [PWR_W-1:0] power;
        logic [BIN_W-1:0] bin;
        logic             frame_end;
        logic             peak_vld;
        logic [PWR_W-1:0] peak_pwr;
        logic [BIN_W-1:0] peak_bin;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_ctl;

    typedef enum logic {
        BK_RUN,
        BK_DUMP
    } t_bk_state;

endpackage

// File: hw/rtl/spk_front.sv
// ----------------------------------------------------------------------------
// spk_front
// Bin power computation, power history and local peak detection.
// ----------------------------------------------------------------------------
module spk_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spk_pkg::t_in  i_in_data,
    input  logic          i_q_full,
    output logic          o_q_push,
    output spk_pkg::t_cmd o_q_data
);
    import spk_pkg::*;

    logic             r_a_vld;
    logic [SQ_W-1:0]  r_a_re2;
    logic [SQ_W-1:0]  r_a_im2;
    logic             r_a_end;
    logic [PWR_W-1:0] r_b1;
    logic [PWR_W-1:0] r_b2;
    logic [CNT_W-1:0] r_cnt;

    logic [MAG_W-1:0]   w_re_mag;
    logic [MAG_W-1:0]   w_im_mag;
    logic [2*MAG_W-1:0] w_re_sq;
    logic [2*MAG_W-1:0] w_im_sq;
    logic [PWR_W-1:0]   w_pw;
    logic               w_push;
    logic               w_peak;
    logic [CNT_W-1:0]   n_cnt;

    always_comb begin
        w_re_mag = i_in_data.real_part[SMP_W-1]
                 ? (MAG_W'(1 << SMP_W) - {1'b0, i_in_data.real_part})
                 : {1'b0, i_in_data.real_part};
        w_im_mag = i_in_data.imag_part[SMP_W-1]
                 ? (MAG_W'(1 << SMP_W) - {1'b0, i_in_data.imag_part})
                 : {1'b0, i_in_data.imag_part};
        w_re_sq  = w_re_mag * w_re_mag;
        w_im_sq  = w_im_mag * w_im_mag;
    end

    assign o_in_ready = !r_a_vld || !i_q_full;
    assign w_push     = r_a_vld && !i_q_full;
    assign w_pw       = {1'b0, r_a_re2} + {1'b0, r_a_im2};
    assign w_peak     = (r_cnt >= CNT_W'(2)) && (r_b1 > r_b2) && (r_b1 > w_pw);
    assign n_cnt      = (r_cnt == CNT_W'(MAX_BINS - 1)) ? '0 : r_cnt + CNT_W'(1);

    always_comb begin
        o_q_push           = w_push;
        o_q_data.power     = w_pw;
        o_q_data.bin       = BIN_W'(r_cnt);
        o_q_data.frame_end = r_a_end;
        o_q_data.peak_vld  = w_peak;
        o_q_data.peak_pwr  = r_b1;
        o_q_data.peak_bin  = BIN_W'(r_cnt - CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b1    <= '0;
            r_b2    <= '0;
            r_cnt   <= '0;
        end else begin
            if (o_in_ready) begin
                r_a_vld <= i_in_valid;
            end
            if (w_push) begin
                if (r_a_end) begin
                    r_b1  <= '0;
                    r_b2  <= '0;
                    r_cnt <= '0;
                end else begin
                    r_b1  <= w_pw;
                    r_b2  <= r_b1;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_a_re2 <= w_re_sq[SQ_W-1:0];
            r_a_im2 <= w_im_sq[SQ_W-1:0];
            r_a_end <= i_in_data.frame_end;
        end
    end

endmodule

// File: hw/rtl/spk_queue.sv
// ----------------------------------------------------------------------------
// spk_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spk_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spk_pkg::t_q_ctl i_ctl,
    output logic           o_full,
    input  spk_pkg::t_cmd  i_data,
    input  logic           i_pop,
    output logic           o_vld,
    output spk_pkg::t_cmd  o_data
);
    import spk_pkg::*;

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full = (r_count == Q_CW'(QUEUE_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_data = r_mem[r_rd];
    assign w_push = i_ctl.push && !o_full;
    assign w_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `SPK_ASSERT(a_no_overflow, !(i_ctl.push && i_ctl.full && o_full), "push into full queue")
    `SPK_ASSERT(a_ptr_count, (r_count == '0 || r_count == Q_CW'(QUEUE_DEPTH)) == (r_wr == r_rd), "queue pointers disagree with count")

endmodule

// File: hw/rtl/spk_back.sv
// ----------------------------------------------------------------------------
// spk_back
// Sorted peak list, power result output and end-of-frame list dump.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spk_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_vld,
    input  spk_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spk_pkg::t_out o_out_data
);
    import spk_pkg::*;

    t_bk_state        r_state;
    t_bk_state        n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [PWR_W-1:0] r_pwr [TOP_COUNT];
    logic [BIN_W-1:0] r_bin [TOP_COUNT];
    logic [PWR_W-1:0] n_pwr [TOP_COUNT];
    logic [BIN_W-1:0] n_bin [TOP_COUNT];
    logic             r_o_vld;
    t_out             r_o_data;
    logic             n_o_load;
    t_out             n_o_data;

    logic                 w_out_free;
    logic [TOP_COUNT-1:0] w_gt;
    logic                 w_sorted;
    logic                 w_empty;

    assign w_out_free  = !r_o_vld || i_out_ready;
    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

    always_comb begin
        for (int j = 0; j < TOP_COUNT; j++) begin
            w_gt[j] = i_q_data.peak_pwr > r_pwr[j];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        o_q_pop  = 1'b0;
        n_o_load = 1'b0;
        n_o_data = r_o_data;
        for (int j = 0; j < TOP_COUNT; j++) begin
            n_pwr[j] = r_pwr[j];
            n_bin[j] = r_bin[j];
        end
        unique case (r_state)
            BK_RUN: begin
                if (i_q_vld && w_out_free) begin
                    o_q_pop              = 1'b1;
                    n_o_load             = 1'b1;
                    n_o_data.item_kind   = KIND_POWER;
                    n_o_data.power_value = i_q_data.power;
                    n_o_data.bin_index   = i_q_data.bin;
                    n_o_data.run_last    = !i_q_data.frame_end;
                    if (i_q_data.peak_vld) begin
                        for (int j = 0; j < TOP_COUNT; j++) begin
                            if (w_gt[j]) begin
                                if (j == 0 || !w_gt[(j > 0) ? j - 1 : 0]) begin
                                    n_pwr[j] = i_q_data.peak_pwr;
                                    n_bin[j] = i_q_data.peak_bin;
                                end else begin
                                    n_pwr[j] = r_pwr[(j > 0) ? j - 1 : 0];
                                    n_bin[j] = r_bin[(j > 0) ? j - 1 : 0];
                                end
                            end
                        end
                    end
                    if (i_q_data.frame_end) begin
                        n_state = BK_DUMP;
                        n_idx   = IDX_W'(TOP_COUNT - 1);
                    end
                end
            end
            BK_DUMP: begin
                if (w_out_free) begin
                    n_o_load             = 1'b1;
                    n_o_data.item_kind   = KIND_PEAK;
                    n_o_data.power_value = r_pwr[r_idx];
                    n_o_data.bin_index   = r_bin[r_idx];
                    n_o_data.run_last    = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = BK_RUN;
                        for (int j = 0; j < TOP_COUNT; j++) begin
                            n_pwr[j] = '0;
                            n_bin[j] = '0;
                        end
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
            r_idx   <= '0;
            r_o_vld <= 1'b0;
            for (int j = 0; j < TOP_COUNT; j++) begin
                r_pwr[j] <= '0;
                r_bin[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (n_o_load) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            for (int j = 0; j < TOP_COUNT; j++) begin
                r_pwr[j] <= n_pwr[j];
                r_bin[j] <= n_bin[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_o_load) begin
            r_o_data <= n_o_data;
        end
    end

    always_comb begin
        w_sorted = 1'b1;
        w_empty  = 1'b1;
        for (int j = 0; j < TOP_COUNT; j++) begin
            if (j > 0 && r_pwr[j] > r_pwr[(j > 0) ? j - 1 : 0]) begin
                w_sorted = 1'b0;
            end
            if (r_pwr[j] != '0 || r_bin[j] != '0) begin
                w_empty = 1'b0;
            end
        end
    end

    `SPK_ASSERT(a_list_sorted, w_sorted, "peak list out of descending order")
    `SPK_ASSERT_NEXT(a_clear_after_dump, r_state == BK_DUMP && r_idx == '0 && w_out_free, w_empty && r_state == BK_RUN, "peak list not cleared after dump")
    `SPK_ASSERT(a_no_pop_in_dump, !(r_state == BK_DUMP && o_q_pop), "queue popped during list dump")

endmodule

// File: hw/rtl/spectral_peak_top_ten.sv
// ----------------------------------------------------------------------------
// spectral_peak_top_ten
// Per-bin power output and ten strongest local peaks per frame.
// ----------------------------------------------------------------------------
// One bin is accepted per cycle while the command queue has room; its power
// passes the square stage, then sum and peak check into the command queue,
// then the output register, before it is valid at the output.
// A bin flagged frame_end gives eleven transactions, its power and then the
// ten list entries weakest first from the output register, one per cycle
// while i_out_ready is high; meanwhile the four-entry command queue and front
// stage accept bins till full. Peak insertion compares all ten slots at once.
module spectral_peak_top_ten (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spk_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spk_pkg::t_out o_out_data
);
    import spk_pkg::*;

    t_q_ctl w_q_ctl;
    t_cmd   w_push_data;
    t_cmd   w_pop_data;
    logic   w_q_full;
    logic   w_q_vld;
    logic   w_q_pop;
    logic   w_push;

    assign w_q_ctl.push = w_push;
    assign w_q_ctl.full = w_q_full;

    spk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_q_push   (w_push),
        .o_q_data   (w_push_data)
    );

    spk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_q_ctl),
        .o_full  (w_q_full),
        .i_data  (w_push_data),
        .i_pop   (w_q_pop),
        .o_vld   (w_q_vld),
        .o_data  (w_pop_data)
    );

    spk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (w_q_vld),
        .i_q_data    (w_pop_data),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
